/* hdl/dba_pkg.sv */
package dba_pkg;

   // cordic datapath widths
   localparam int CW    = 36;
   localparam int ZW    = 34;
   localparam int NW    = 30;
   localparam int PRW   = NW + 32;
   localparam int STEPS = 30;

   localparam logic signed [31:0] KQ = 32'sd1768195363;

   localparam logic [31:0] QUARTER     = 32'h4000_0000;
   localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;
   localparam logic [31:0] HALF        = 32'h8000_0000;

   localparam logic signed [ZW-1:0] QUARTER_Z = 34'sd1073741824;
   localparam logic signed [ZW-1:0] HALF_Z    = 34'sd2147483648;

   localparam logic [31:0] ATAN_TAB [STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   typedef struct packed {
      logic hz1;
      logic u1zero;
      logic u1neg;
      logic x0neg;
      logic x0zero;
      logic y0zero;
      logic y0pos;
   } vec1_flags_type;

   typedef struct packed {
      logic signed [NW-1:0] n2e;
      logic signed [NW-1:0] n2n;
      logic signed [CW-1:0] uk;
      logic signed [CW-1:0] pu;
      vec1_flags_type       f;
   } vec1_side_type;

   typedef struct packed {
      logic [31:0]          head;
      logic signed [CW-1:0] pu;
      logic                 hz1;
      logic                 u1zero;
      logic                 u1neg;
   } rot1_side_type;

   typedef struct packed {
      logic signed [CW-1:0] pe;
      logic [31:0]          pitch;
      logic [31:0]          head;
      logic                 hz1;
   } rot2_side_type;

   typedef struct packed {
      logic [31:0] pitch;
      logic [31:0] head;
      logic        hz1;
      logic        pezero;
      logic        puzero;
      logic        puneg;
   } vec3_side_type;

endpackage

/* hdl/dba_cordic.sv */
module dba_cordic #(
   parameter bit VECTOR = 1'b1,
   parameter int SW     = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [dba_pkg::CW-1:0]   in_x,
   input  logic signed [dba_pkg::CW-1:0]   in_y,
   input  logic signed [dba_pkg::ZW-1:0]   in_z,
   input  logic [SW-1:0]                   in_side,
   output logic                            out_valid,
   output logic signed [dba_pkg::CW-1:0]   out_x,
   output logic signed [dba_pkg::CW-1:0]   out_y,
   output logic signed [dba_pkg::ZW-1:0]   out_z,
   output logic [SW-1:0]                   out_side
);

   localparam int N = dba_pkg::STEPS;

   logic                          vs [N+1];
   logic signed [dba_pkg::CW-1:0] xs [N+1];
   logic signed [dba_pkg::CW-1:0] ys [N+1];
   logic signed [dba_pkg::ZW-1:0] zs [N+1];
   logic [SW-1:0]                 ss [N+1];

   assign vs[0] = in_valid;
   assign xs[0] = in_x;
   assign ys[0] = in_y;
   assign zs[0] = in_z;
   assign ss[0] = in_side;

   for (genvar i = 0; i < N; i++) begin : g_step
      logic                          v_ff;
      logic signed [dba_pkg::CW-1:0] x_ff, y_ff, xsh, ysh;
      logic signed [dba_pkg::ZW-1:0] z_ff, at;
      logic [SW-1:0]                 s_ff;
      logic                          pos;

      assign xsh = xs[i] >>> i;
      assign ysh = ys[i] >>> i;
      assign at  = $signed({2'b00, dba_pkg::ATAN_TAB[i]});

      // vectoring drives y to zero, rotation drives the angle to zero
      if (VECTOR) begin : g_vec
         assign pos = ys[i][dba_pkg::CW-1];
      end else begin : g_rot
         assign pos = !zs[i][dba_pkg::ZW-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= vs[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff <= pos ? xs[i] - ysh : xs[i] + ysh;
            y_ff <= pos ? ys[i] + xsh : ys[i] - xsh;
            z_ff <= pos ? zs[i] - at : zs[i] + at;
            s_ff <= ss[i];
         end
      end

      assign vs[i+1] = v_ff;
      assign xs[i+1] = x_ff;
      assign ys[i+1] = y_ff;
      assign zs[i+1] = z_ff;
      assign ss[i+1] = s_ff;
   end

   assign out_valid = vs[N];
   assign out_x     = xs[N];
   assign out_y     = ys[N];
   assign out_z     = zs[N];
   assign out_side  = ss[N];

endmodule

/* hdl/dual_baseline_attitude_top.sv */
// channel   dir  handshake               payload
// req       in   req_valid / req_stall   origin, first, second antenna e/n/u
// rsp       out  rsp_valid / rsp_stall   roll, pitch, heading, degenerate
//
// one request per cycle sustained while the response is not stalled; the path is
// 9 register stages plus four 30-step cordic pipelines (vector, rotate with pitch
// vector alongside, rotate, vector)
// reset is synchronous and clears only the valid bits
// a stalled response freezes the whole pipeline, req_stall follows at once
module dual_baseline_attitude_top #(
   parameter int COORD_WIDTH = 21,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_origin_east,
   input  logic signed [COORD_WIDTH-1:0] req_origin_north,
   input  logic signed [COORD_WIDTH-1:0] req_origin_up,
   input  logic signed [COORD_WIDTH-1:0] req_first_east,
   input  logic signed [COORD_WIDTH-1:0] req_first_north,
   input  logic signed [COORD_WIDTH-1:0] req_first_up,
   input  logic signed [COORD_WIDTH-1:0] req_second_east,
   input  logic signed [COORD_WIDTH-1:0] req_second_north,
   input  logic signed [COORD_WIDTH-1:0] req_second_up,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0] rsp_roll_angle,
   output logic signed [ANGLE_WIDTH-1:0] rsp_pitch_angle,
   output logic signed [ANGLE_WIDTH-1:0] rsp_heading_angle,
   output logic                          rsp_degenerate
);

   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = $clog2(DW);
   localparam int SHW = DW + 28;
   localparam int CW  = dba_pkg::CW;
   localparam int ZW  = dba_pkg::ZW;
   localparam int NW  = dba_pkg::NW;
   localparam int PRW = dba_pkg::PRW;
   localparam int PEW = 33 + 32;

   function automatic logic [DW-1:0] mag_of(logic signed [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   function automatic logic [PW-1:0] msb_of(logic [DW-1:0] m);
      logic [PW-1:0] r;
      r = '0;
      for (int i = 0; i < DW; i++) begin
         if (m[i]) begin
            r = PW'(i);
         end
      end
      return r;
   endfunction

   // floor(v * 2^(28 - p)), puts the largest component in [2^28, 2^29)
   function automatic logic signed [NW-1:0] normalize(logic signed [DW-1:0] v,
                                                      logic [PW-1:0] p);
      logic signed [SHW-1:0] w;
      w = SHW'(v) <<< 28;
      w = w >>> p;
      return w[NW-1:0];
   endfunction

   // round half up to the output angle width, wrapping
   function automatic logic [ANGLE_WIDTH-1:0] to_out(logic [31:0] z);
      logic [32:0] t;
      t = {1'b0, z} + (33'd1 << (31 - ANGLE_WIDTH));
      return t[31:32-ANGLE_WIDTH];
   endfunction

   logic adv;
   logic rsp_valid_ff;

   // whole pipeline moves unless a finished response is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: baselines
   logic                 v1_ff;
   logic signed [DW-1:0] d1_ff [3];
   logic signed [DW-1:0] d2_ff [3];
   logic signed [DW-1:0] d1_in [3];
   logic signed [DW-1:0] d2_in [3];

   always_comb begin
      d1_in[0] = DW'(req_first_east)   - DW'(req_origin_east);
      d1_in[1] = DW'(req_first_north)  - DW'(req_origin_north);
      d1_in[2] = DW'(req_first_up)     - DW'(req_origin_up);
      d2_in[0] = DW'(req_second_east)  - DW'(req_origin_east);
      d2_in[1] = DW'(req_second_north) - DW'(req_origin_north);
      d2_in[2] = DW'(req_second_up)    - DW'(req_origin_up);
   end

   // stage 2: or of magnitudes has the same top bit as the largest one
   logic                 v2_ff;
   logic [DW-1:0]        m1_ff, m2_ff;
   logic signed [DW-1:0] a1_ff [3];
   logic signed [DW-1:0] a2_ff [3];

   // stage 3: top bit position
   logic                 v3_ff;
   logic [PW-1:0]        p1_ff, p2_ff;
   logic signed [DW-1:0] b1_ff [3];
   logic signed [DW-1:0] b2_ff [3];

   // stage 4: normalized baselines
   logic                 v4_ff;
   logic signed [NW-1:0] n1_ff [3];
   logic signed [NW-1:0] n2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         m1_ff <= mag_of(d1_ff[0]) | mag_of(d1_ff[1]) | mag_of(d1_ff[2]);
         m2_ff <= mag_of(d2_ff[0]) | mag_of(d2_ff[1]) | mag_of(d2_ff[2]);
         a1_ff <= d1_ff;
         a2_ff <= d2_ff;
         p1_ff <= msb_of(m1_ff);
         p2_ff <= msb_of(m2_ff);
         b1_ff <= a1_ff;
         b2_ff <= a2_ff;
         for (int k = 0; k < 3; k++) begin
            n1_ff[k] <= normalize(b1_ff[k], p1_ff);
            n2_ff[k] <= normalize(b2_ff[k], p2_ff);
         end
      end
   end

   // stage 5: heading vector setup, up components times cordic gain
   logic                    v5_ff;
   logic signed [CW-1:0]    vx_ff, vy_ff;
   logic signed [ZW-1:0]    vz_ff;
   logic signed [PRW-1:0]   ukp_ff, pup_ff;
   logic signed [NW-1:0]    e2_ff, nn2_ff;
   dba_pkg::vec1_flags_type f1_ff, f1_in;

   always_comb begin
      f1_in.x0neg  = n1_ff[1][NW-1];
      f1_in.x0zero = (n1_ff[1] == '0);
      f1_in.y0zero = (n1_ff[0] == '0);
      f1_in.y0pos  = !n1_ff[0][NW-1] && (n1_ff[0] != '0);
      f1_in.hz1    = f1_in.x0zero && f1_in.y0zero;
      f1_in.u1zero = (n1_ff[2] == '0);
      f1_in.u1neg  = n1_ff[2][NW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // north component negative: turn by half first
         vx_ff  <= n1_ff[1][NW-1] ? -CW'(n1_ff[1]) : CW'(n1_ff[1]);
         vy_ff  <= n1_ff[1][NW-1] ? -CW'(n1_ff[0]) : CW'(n1_ff[0]);
         vz_ff  <= n1_ff[1][NW-1] ? dba_pkg::HALF_Z : '0;
         ukp_ff <= n1_ff[2] * dba_pkg::KQ;
         pup_ff <= n2_ff[2] * dba_pkg::KQ;
         e2_ff  <= n2_ff[0];
         nn2_ff <= n2_ff[1];
         f1_ff  <= f1_in;
      end
   end

   dba_pkg::vec1_side_type s1_in, s1_out;
   logic                   c1_valid;
   logic signed [CW-1:0]   c1_x, c1_y;
   logic signed [ZW-1:0]   c1_z;

   always_comb begin
      s1_in.n2e = e2_ff;
      s1_in.n2n = nn2_ff;
      s1_in.uk  = CW'($signed(ukp_ff[PRW-1:30]));
      s1_in.pu  = CW'($signed(pup_ff[PRW-1:30]));
      s1_in.f   = f1_ff;
   end

   dba_cordic #(.VECTOR(1'b1), .SW($bits(dba_pkg::vec1_side_type))) u_head (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v5_ff), .in_x(vx_ff), .in_y(vy_ff), .in_z(vz_ff), .in_side(s1_in),
      .out_valid(c1_valid), .out_x(c1_x), .out_y(c1_y), .out_z(c1_z),
      .out_side(s1_out)
   );

   // stage 6: heading with exact axis cases, gamma folded into +-quarter
   logic                 v6_ff;
   logic [31:0]          head_in;
   logic signed [ZW-1:0] gam_in;
   logic signed [CW-1:0] mag_ff, uk_ff;
   logic                 ukz_ff;
   logic signed [ZW-1:0] gam_ff;
   dba_pkg::rot1_side_type r1_ff;
   logic signed [CW-1:0] re_ff, rn_ff;

   always_comb begin
      if (s1_out.f.hz1) begin
         head_in = '0;
      end else if (s1_out.f.y0zero) begin
         head_in = s1_out.f.x0neg ? dba_pkg::HALF : '0;
      end else if (s1_out.f.x0zero) begin
         head_in = s1_out.f.y0pos ? dba_pkg::QUARTER : dba_pkg::QUARTER_NEG;
      end else begin
         head_in = c1_z[31:0];
      end
      gam_in = ZW'($signed(head_in));
      if (gam_in > dba_pkg::QUARTER_Z) begin
         gam_in = gam_in - dba_pkg::HALF_Z;
      end else if (gam_in < -dba_pkg::QUARTER_Z) begin
         gam_in = gam_in + dba_pkg::HALF_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= c1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff       <= c1_x;
         uk_ff        <= s1_out.uk;
         ukz_ff       <= (s1_out.uk == '0);
         gam_ff       <= gam_in;
         re_ff        <= CW'(s1_out.n2e);
         rn_ff        <= CW'(s1_out.n2n);
         r1_ff.head   <= head_in;
         r1_ff.pu     <= s1_out.pu;
         r1_ff.hz1    <= s1_out.f.hz1;
         r1_ff.u1zero <= s1_out.f.u1zero;
         r1_ff.u1neg  <= s1_out.f.u1neg;
      end
   end

   // second baseline turned by gamma, pitch vector alongside
   dba_pkg::rot1_side_type r1_out;
   logic                   c2_valid, c3_valid;
   logic signed [CW-1:0]   c2_x, c2_y, c3_x, c3_y;
   logic signed [ZW-1:0]   c2_z, c3_z;
   logic                   ukz_out;

   dba_cordic #(.VECTOR(1'b0), .SW($bits(dba_pkg::rot1_side_type))) u_turn (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v6_ff), .in_x(re_ff), .in_y(rn_ff), .in_z(gam_ff), .in_side(r1_ff),
      .out_valid(c2_valid), .out_x(c2_x), .out_y(c2_y), .out_z(c2_z),
      .out_side(r1_out)
   );

   dba_cordic #(.VECTOR(1'b1), .SW(1)) u_pitch (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v6_ff), .in_x(mag_ff), .in_y(uk_ff), .in_z('0), .in_side(ukz_ff),
      .out_valid(c3_valid), .out_x(c3_x), .out_y(c3_y), .out_z(c3_z),
      .out_side(ukz_out)
   );

   // stage 7: pitch and rotated east times gain
   logic                 v7_ff;
   logic [31:0]          pitch_in;
   logic signed [PEW-1:0] pep_ff;
   logic signed [CW-1:0] y1_ff, pu_ff;
   logic [31:0]          pitch_ff, head7_ff;
   logic                 hz7_ff;

   always_comb begin
      if (r1_out.hz1) begin
         if (r1_out.u1zero) begin
            pitch_in = '0;
         end else begin
            pitch_in = r1_out.u1neg ? dba_pkg::QUARTER_NEG : dba_pkg::QUARTER;
         end
      end else begin
         pitch_in = ukz_out ? '0 : c3_z[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= c2_valid && c3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pep_ff   <= $signed(c2_x[32:0]) * dba_pkg::KQ;
         y1_ff    <= c2_y;
         pu_ff    <= r1_out.pu;
         pitch_ff <= pitch_in;
         head7_ff <= r1_out.head;
         hz7_ff   <= r1_out.hz1;
      end
   end

   // up/north plane turned by pitch
   dba_pkg::rot2_side_type r2_in, r2_out;
   logic                   c4_valid;
   logic signed [CW-1:0]   c4_x, c4_y;
   logic signed [ZW-1:0]   c4_z;

   always_comb begin
      r2_in.pe    = CW'($signed(pep_ff[PEW-1:30]));
      r2_in.pitch = pitch_ff;
      r2_in.head  = head7_ff;
      r2_in.hz1   = hz7_ff;
   end

   dba_cordic #(.VECTOR(1'b0), .SW($bits(dba_pkg::rot2_side_type))) u_tilt (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v7_ff), .in_x(pu_ff), .in_y(y1_ff), .in_z(ZW'($signed(pitch_ff))),
      .in_side(r2_in),
      .out_valid(c4_valid), .out_x(c4_x), .out_y(c4_y), .out_z(c4_z),
      .out_side(r2_out)
   );

   // stage 9: roll vector setup, east made positive
   logic                   v9_ff;
   logic signed [CW-1:0]   rx_ff, ry_ff;
   dba_pkg::vec3_side_type r3_ff, r3_out;
   logic                   pe_pos;

   assign pe_pos = !r2_out.pe[CW-1] && (r2_out.pe != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (adv) begin
         v9_ff <= c4_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff        <= pe_pos ? r2_out.pe : -r2_out.pe;
         ry_ff        <= pe_pos ? -c4_x : c4_x;
         r3_ff.pitch  <= r2_out.pitch;
         r3_ff.head   <= r2_out.head;
         r3_ff.hz1    <= r2_out.hz1;
         r3_ff.pezero <= (r2_out.pe == '0);
         r3_ff.puzero <= (c4_x == '0);
         r3_ff.puneg  <= c4_x[CW-1];
      end
   end

   logic                 c5_valid;
   logic signed [CW-1:0] c5_x, c5_y;
   logic signed [ZW-1:0] c5_z;

   dba_cordic #(.VECTOR(1'b1), .SW($bits(dba_pkg::vec3_side_type))) u_roll (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v9_ff), .in_x(rx_ff), .in_y(ry_ff), .in_z('0), .in_side(r3_ff),
      .out_valid(c5_valid), .out_x(c5_x), .out_y(c5_y), .out_z(c5_z),
      .out_side(r3_out)
   );

   // stage 10: response register
   logic [31:0]            roll_in;
   logic [ANGLE_WIDTH-1:0] roll_ff, pitch_o_ff, head_o_ff;
   logic                   degen_ff;

   always_comb begin
      if (r3_out.pezero) begin
         if (r3_out.puzero) begin
            roll_in = '0;
         end else begin
            roll_in = r3_out.puneg ? dba_pkg::QUARTER : dba_pkg::QUARTER_NEG;
         end
      end else begin
         roll_in = r3_out.puzero ? '0 : c5_z[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c5_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff    <= to_out(roll_in);
         pitch_o_ff <= to_out(r3_out.pitch);
         head_o_ff  <= to_out(r3_out.head);
         degen_ff   <= r3_out.hz1 || (r3_out.pezero && r3_out.puzero);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_o_ff;
   assign rsp_heading_angle = head_o_ff;
   assign rsp_degenerate    = degen_ff;

   // a held response must back-pressure the request side
   a_stall_back : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("held response without request stall");

   // degenerate means zero heading or zero roll
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && degen_ff |-> (head_o_ff == '0) || (roll_ff == '0))
      else $error("degenerate response with nonzero heading and roll");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   // a stalled response must not be overwritten by the pipeline
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(roll_ff) && $stable(head_o_ff))
      else $error("stalled response changed");

endmodule
